FILE: sv/mru_replacement_ranks_unit_macros.svh
// Assertion macros shared by the mru replacement ranks unit.
`ifndef MRU_REPLACEMENT_RANKS_UNIT_MACROS_SVH
`define MRU_REPLACEMENT_RANKS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// cond must never hold at a clock edge out of reset
`define MRR_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("mrr assertion failed: forbidden condition seen");
// ante at an edge requires cons at the same edge
`define MRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mrr assertion failed: implication broken");
`else
`define MRR_ASSERT_NEVER(label, clk, rst_n, cond)
`define MRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/mrr_pkg.sv
// Shared types and codes of the mru replacement ranks unit.
package mrr_pkg;

	localparam int RANK_W     = 4;
	localparam int MAX_WAYS   = 16;
	localparam int SET_W      = 11;
	localparam int WAY_W      = 4;
	localparam int MAX_ADDR_W = 16;

	// Item kinds on the input port
	localparam logic [1:0] KIND_QUERY  = 2'd0;
	localparam logic [1:0] KIND_FILL   = 2'd1;
	localparam logic [1:0] KIND_UPDATE = 2'd2;

	// Operations queued for the back end
	typedef logic op_t;
	localparam op_t OP_PROMOTE = 1'b0;
	localparam op_t OP_QUERY   = 1'b1;

	typedef struct packed {
		op_t                   op;
		logic [SET_W-1:0]      set_index;
		logic [WAY_W-1:0]      way;
		logic [MAX_WAYS-1:0]   valid_mask;
		logic                  set_ok;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_status_t;

endpackage

FILE: sv/mru_replacement_ranks_unit.sv
// Top level of the mru replacement ranks unit: front, queue and back end.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  item in   start & !busy        kind, set_index, way, valid_mask, hit,
//                                 is_writeback
//  result    result_valid strobe  victim_way (victim queries only)
//
//  Each queued item takes a rank row read, then a modify and write-back or a
//  victim pick; the back end pops no new item while one is still in flight.
//  No-op items are dropped at the front and take no back-end time. A victim
//  is registered after stage s1, which its pop loads from the queue head.
//  After reset the rank RAM is cleared one row a cycle, busy high; busy also
//  rises when the 2-entry queue fills. The receiver cannot stall.
`include "mru_replacement_ranks_unit_macros.svh"

module mru_replacement_ranks_unit #(
	parameter int SETS = 2048,
	parameter int WAYS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    kind,
	input  logic [mrr_pkg::SET_W-1:0]     set_index,
	input  logic [mrr_pkg::WAY_W-1:0]     way,
	input  logic [mrr_pkg::MAX_WAYS-1:0]  valid_mask,
	input  logic                          hit,
	input  logic                          is_writeback,
	output logic                          result_valid,
	output logic [mrr_pkg::WAY_W-1:0]     victim_way
);

	mrr_pkg::item_t         push_item;
	mrr_pkg::item_t         head;
	mrr_pkg::q_status_t     q_st;
	mrr_pkg::back_status_t  back_st;
	logic                   push;

	// Front: handshake and classification
	mrr_front #(
		.SETS(SETS),
		.WAYS(WAYS)
	) u_front (
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.set_index    (set_index),
		.way          (way),
		.valid_mask   (valid_mask),
		.hit          (hit),
		.is_writeback (is_writeback),
		.q_st         (q_st),
		.back_st      (back_st),
		.push         (push),
		.item         (push_item)
	);

	// Decouples the accept side from the read-modify-write side
	mrr_queue #(
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (back_st.pop),
		.head      (head),
		.st        (q_st)
	);

	// Back: rank table and victim selection
	mrr_back #(
		.SETS(SETS),
		.WAYS(WAYS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_st         (q_st),
		.st           (back_st),
		.result_valid (result_valid),
		.victim_way   (victim_way)
	);

	// No port traffic and no table work leaks out during the clearing pass
	`MRR_ASSERT_IMPLY(a_busy_while_clearing, clk, arst_n, back_st.clearing, busy)
	`MRR_ASSERT_NEVER(a_no_result_while_clearing, clk, arst_n, result_valid && back_st.clearing)
	// Back end handles one item at a time, so results never come back to back
	`MRR_ASSERT_IMPLY(a_result_spacing, clk, arst_n, result_valid, !$past(result_valid))
	// A pop needs something in the queue
	`MRR_ASSERT_NEVER(a_pop_nonempty, clk, arst_n, back_st.pop && q_st.empty)

endmodule

FILE: sv/mrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/mrr_front.sv
// Front end: takes items from the port, classifies them and queues real work.
module mrr_front #(
	parameter int SETS = 2048,
	parameter int WAYS = 16
) (
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    kind,
	input  logic [mrr_pkg::SET_W-1:0]     set_index,
	input  logic [mrr_pkg::WAY_W-1:0]     way,
	input  logic [mrr_pkg::MAX_WAYS-1:0]  valid_mask,
	input  logic                          hit,
	input  logic                          is_writeback,
	input  mrr_pkg::q_status_t            q_st,
	input  mrr_pkg::back_status_t         back_st,
	output logic                          push,
	output mrr_pkg::item_t                item
);

	logic accept;
	logic set_ok;
	logic way_ok;
	logic keep;

	assign busy   = back_st.clearing || q_st.full;
	assign accept = start && !busy;

	assign set_ok = 17'(set_index) < 17'(SETS);
	assign way_ok = 5'(way) < 5'(WAYS);

	// Misses, writeback hits, unused kinds and out-of-range fill or update targets do nothing
	always_comb begin
		item.op         = mrr_pkg::OP_PROMOTE;
		item.set_index  = set_index;
		item.way        = way;
		item.valid_mask = valid_mask;
		item.set_ok     = set_ok;
		keep            = 1'b0;
		unique case (kind)
			mrr_pkg::KIND_QUERY: begin
				item.op = mrr_pkg::OP_QUERY;
				keep    = 1'b1;
			end
			mrr_pkg::KIND_FILL: begin
				keep = set_ok && way_ok;
			end
			mrr_pkg::KIND_UPDATE: begin
				keep = set_ok && way_ok && hit && !is_writeback;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = accept && keep;

endmodule

FILE: sv/mrr_queue.sv
// Short FIFO of classified items between front and back end.
module mrr_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mrr_pkg::item_t      push_item,
	input  logic                pop,
	output mrr_pkg::item_t      head,
	output mrr_pkg::q_status_t  st
);

	localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mrr_pkg::item_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign st.full  = count_q == CNT_W'(DEPTH);
	assign st.empty = count_q == '0;
	assign do_push  = push && !st.full;
	assign do_pop   = pop && !st.empty;
	assign head     = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: sv/mrr_back.sv
// Back end: rank table, clearing pass, promote write-back and victim pick.
module mrr_back #(
	parameter int SETS = 2048,
	parameter int WAYS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mrr_pkg::item_t               head,
	input  mrr_pkg::q_status_t           q_st,
	output mrr_pkg::back_status_t        st,
	output logic                         result_valid,
	output logic [mrr_pkg::WAY_W-1:0]    victim_way
);

	localparam int AW    = SETS > 1 ? $clog2(SETS) : 1;
	localparam int RW    = mrr_pkg::RANK_W;
	localparam int ROW_W = WAYS * RW;

	// Lowest set bit of a way vector
	function automatic logic [mrr_pkg::WAY_W-1:0] lowest(input logic [WAYS-1:0] v);
		logic [mrr_pkg::WAY_W-1:0] r;
		r = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = mrr_pkg::WAY_W'(i);
			end
		end
		return r;
	endfunction

	logic                       clearing_q;
	logic [AW-1:0]              clr_q;
	logic                       valid_s1;
	mrr_pkg::item_t             item_s1;
	logic                       result_valid_q;
	logic [mrr_pkg::WAY_W-1:0]  victim_way_q;

	logic                       pop;
	logic [mrr_pkg::MAX_ADDR_W:0] head_addr_ext;
	logic [mrr_pkg::MAX_ADDR_W:0] s1_addr_ext;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [ROW_W-1:0]           ram_wdata;
	logic [ROW_W-1:0]           row;
	logic [ROW_W-1:0]           new_row;
	logic [WAYS-1:0]            invalid;
	logic [WAYS-1:0]            zero_rank;
	logic [mrr_pkg::WAY_W-1:0]  pick;

	// One item in flight: read the row, then modify/write or answer
	assign pop           = !clearing_q && !valid_s1 && !q_st.empty;
	assign st.clearing   = clearing_q;
	assign st.pop        = pop;
	assign head_addr_ext = (mrr_pkg::MAX_ADDR_W + 1)'(head.set_index);
	assign s1_addr_ext   = (mrr_pkg::MAX_ADDR_W + 1)'(item_s1.set_index);

	mrr_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop),
		.raddr (head_addr_ext[AW-1:0]),
		.rdata (row)
	);

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			if (mrr_pkg::WAY_W'(i) == item_s1.way) begin
				new_row[i*RW +: RW] = '0;
			end else if (row[i*RW +: RW] < RW'(WAYS - 1)) begin
				new_row[i*RW +: RW] = row[i*RW +: RW] + 1'b1;
			end else begin
				new_row[i*RW +: RW] = row[i*RW +: RW];
			end
			invalid[i]   = !item_s1.valid_mask[i];
			zero_rank[i] = !item_s1.set_ok || (row[i*RW +: RW] == '0);
		end
	end

	always_comb begin
		priority if (invalid != '0) begin
			pick = lowest(invalid);
		end else if (zero_rank != '0) begin
			pick = lowest(zero_rank);
		end else begin
			pick = '0;
		end
	end

	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = valid_s1 && (item_s1.op == mrr_pkg::OP_PROMOTE);
			ram_waddr = s1_addr_ext[AW-1:0];
			ram_wdata = new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q     <= 1'b1;
			clr_q          <= '0;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_q == AW'(SETS - 1)) begin
					clearing_q <= 1'b0;
				end
				clr_q <= clr_q + 1'b1;
			end
			valid_s1       <= pop;
			result_valid_q <= valid_s1 && (item_s1.op == mrr_pkg::OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
		end
		if (valid_s1) begin
			victim_way_q <= pick;
		end
	end

	assign result_valid = result_valid_q;
	assign victim_way   = victim_way_q;

endmodule
